// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL tree.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBSI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RBSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RBSI_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RBSI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray / box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;
   localparam int QW       = 32;             // Q16.16 word
   localparam int DW       = QW + 1;         // exact difference
   localparam int FRAC     = 16;
   localparam int WW       = 2 * DW - 1;     // divider working width
   localparam int DIV_LAT  = QW + 2;         // setup, one stage per bit, saturate

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [DW-1:0] dif_type;
   typedef logic        [WW-1:0] wide_type;

   localparam q_type Q_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam q_type Q_MIN = {1'b1, {(QW-1){1'b0}}};

   typedef struct packed {
      logic  ok;
      q_type near_t;
      q_type far_t;
   } slab_type;
endpackage

// File: hw/rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined signed (num * 2^16) / den, truncated toward zero, saturated.
// One quotient bit per stage; stages advance only while en is high.
// ----------------------------------------------------------------------------
module rbsi_div (
   input  logic            clock,
   input  logic            en,
   input  rbsi_pkg::dif_type num_in,
   input  rbsi_pkg::dif_type den_in,
   output rbsi_pkg::q_type  quo_out
);
   import rbsi_pkg::*;

   logic [DW-1:0] an, ad;
   wide_type      n_sh;

   wide_type          rem_ff [0:QW-1];
   logic [QW-1:0]     quo_ff [0:QW];
   logic [DW-1:0]     den_ff [0:QW-1];
   logic              neg_ff [0:QW];
   logic              ovf_ff [0:QW];
   q_type             res_ff;

   always_comb begin
      an   = num_in[DW-1] ? DW'(-num_in) : DW'(num_in);
      ad   = den_in[DW-1] ? DW'(-den_in) : DW'(den_in);
      n_sh = WW'({an, {FRAC{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= n_sh;
         quo_ff[0] <= '0;
         den_ff[0] <= ad;
         neg_ff[0] <= num_in[DW-1] ^ den_in[DW-1];
         // quotient of 2^32 or more always saturates
         ovf_ff[0] <= n_sh >= (WW'(ad) << QW);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      wide_type trial;
      logic     take;
      assign trial = WW'(den_ff[k]) << (QW - 1 - k);
      assign take  = rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            if (take)
               quo_ff[k+1] <= quo_ff[k] | (QW'(1) << (QW - 1 - k));
            else
               quo_ff[k+1] <= quo_ff[k];
         end
      end
      // the last stage needs no remainder or divisor beyond it
      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[k+1] <= den_ff[k];
               if (take) rem_ff[k+1] <= rem_ff[k] - trial;
               else      rem_ff[k+1] <= rem_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (neg_ff[QW]) begin
            if (ovf_ff[QW] || (quo_ff[QW][QW-1] && quo_ff[QW][QW-2:0] != '0))
               res_ff <= Q_MIN;
            else
               res_ff <= q_type'(-quo_ff[QW]);
         end else begin
            if (ovf_ff[QW] || quo_ff[QW][QW-1])
               res_ff <= Q_MAX;
            else
               res_ff <= q_type'(quo_ff[QW]);
         end
      end
   end

   assign quo_out = res_ff;
endmodule

// File: hw/rtl/ray_box_slab_intersect.sv
// Stages: prep, 34 divider, slab and two merge stages, from input transfer to
//   result transfer; the whole pipeline holds while the result side stalls.
// Throughput: one test per cycle unless stalled (32-stage pipelined dividers).
// Reset: synchronous, clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab test of a segment line against an axis-aligned box, Q16.16.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ray_box_slab_intersect (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // entry_param
   output logic [0:0]   rsp_tuser    // hit
);
   import rbsi_pkg::*;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic    vld_ff [0:DIV_LAT];
   logic    zero_ff [0:DIV_LAT][3];
   logic    ins_ff  [0:DIV_LAT][3];
   dif_type lo_ff [3];
   dif_type hi_ff [3];
   dif_type dir_ff [3];
   q_type   qa [3];
   q_type   qb [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      dif_type s, e, lo, hi, d;
      logic    ins;
      always_comb begin
         s  = DW'(signed'(req_tdata[a*QW +: QW]));
         e  = DW'(signed'(req_tdata[(a+3)*QW +: QW]));
         lo = DW'(signed'(req_tdata[(a+6)*QW +: QW]));
         hi = DW'(signed'(req_tdata[(a+9)*QW +: QW]));
         d  = e - s;
         if (lo < hi) ins = (s >= lo) && (s <= hi);
         else         ins = (s >= hi) && (s <= lo);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            lo_ff[a]      <= lo - s;
            hi_ff[a]      <= hi - s;
            dir_ff[a]     <= d;
            zero_ff[0][a] <= d == '0;
            ins_ff[0][a]  <= ins;
         end
      end
      rbsi_div u_div_lo (.clock(clock), .en(en), .num_in(lo_ff[a]), .den_in(dir_ff[a]),
                         .quo_out(qa[a]));
      rbsi_div u_div_hi (.clock(clock), .en(en), .num_in(hi_ff[a]), .den_in(dir_ff[a]),
                         .quo_out(qb[a]));
   end

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[k+1] <= zero_ff[k];
            ins_ff[k+1]  <= ins_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 0; k < DIV_LAT; k++) vld_ff[k+1] <= vld_ff[k];
      end
   end

   // per-axis interval
   slab_type slab_in [3];
   slab_type slab_ff [3];
   logic     c1_vld_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (zero_ff[DIV_LAT][a]) begin
            slab_in[a].ok     = ins_ff[DIV_LAT][a];
            slab_in[a].near_t = Q_MIN;
            slab_in[a].far_t  = Q_MAX;
         end else begin
            slab_in[a].ok     = 1'b1;
            slab_in[a].near_t = (qa[a] > qb[a]) ? qb[a] : qa[a];
            slab_in[a].far_t  = (qa[a] > qb[a]) ? qa[a] : qb[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) slab_ff <= slab_in;
   end

   // merge x with y
   logic     c2_vld_ff, miss2_ff;
   q_type    tmin2_ff, tmax2_ff;
   slab_type z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         miss2_ff <= !slab_ff[0].ok || !slab_ff[1].ok
                     || (slab_ff[0].near_t > slab_ff[1].far_t)
                     || (slab_ff[1].near_t > slab_ff[0].far_t);
         tmin2_ff <= (slab_ff[1].near_t > slab_ff[0].near_t) ? slab_ff[1].near_t
                                                             : slab_ff[0].near_t;
         tmax2_ff <= (slab_ff[1].far_t < slab_ff[0].far_t) ? slab_ff[1].far_t
                                                           : slab_ff[0].far_t;
         z_ff     <= slab_ff[2];
      end
   end

   // merge with z, output register
   logic  out_vld_ff, hit_ff, hit_in;
   q_type entry_ff;

   assign hit_in = !(miss2_ff || !z_ff.ok || (tmin2_ff > z_ff.far_t)
                     || (z_ff.near_t > tmax2_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         if (!hit_in)                      entry_ff <= '0;
         else if (z_ff.near_t > tmin2_ff)  entry_ff <= z_ff.near_t;
         else                              entry_ff <= tmin2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         c1_vld_ff  <= vld_ff[DIV_LAT];
         c2_vld_ff  <= c1_vld_ff;
         out_vld_ff <= c2_vld_ff;
      end
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = entry_ff;
   assign rsp_tuser[0] = hit_ff;

   `RBSI_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)
   `RBSI_ASSERT_NEXT(a_accept_vld, clock, reset, req_tvalid && req_tready, vld_ff[0])
   `RBSI_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, c2_vld_ff == $past(c2_vld_ff))
endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the ray / box slab intersection block: directed corner cases
// and random segments and boxes, results checked against a local slab predictor
// under varied source idle and sink stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import rbsi_pkg::*;

   typedef struct packed {
      logic        hit;
      logic [31:0] entry;
   } isect_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [383:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   ray_box_slab_intersect uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   logic [383:0] ray_queue[$];
   isect_type    isect_expected[$];
   int           src_idle_pct = 0;
   int           snk_stall_pct = 0;
   int           hold_off = 0;
   int           mismatches = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // (num * 2^16) / den truncated toward zero, saturated to Q16.16
   function automatic longint q_divide(longint num, longint den);
      bit          neg;
      logic [63:0] n, d, q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n << 16) / d;
      if (neg) return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
      return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
   endfunction

   function automatic isect_type predict_isect(logic [383:0] ray);
      isect_type r;
      longint    s, e, lo, hi, d, a, b, t, tmin, tmax;
      r = '0;
      tmin = 0;
      tmax = 0;
      for (int ax = 0; ax < 3; ax++) begin
         s  = longint'(signed'(ray[32*ax +: 32]));
         e  = longint'(signed'(ray[32*(3+ax) +: 32]));
         lo = longint'(signed'(ray[32*(6+ax) +: 32]));
         hi = longint'(signed'(ray[32*(9+ax) +: 32]));
         d = e - s;
         if (d == 0) begin
            if (lo > hi) begin t = lo; lo = hi; hi = t; end
            if (s < lo || s > hi) return r;
            a = -64'sd2147483648;
            b = 64'sd2147483647;
         end else begin
            a = q_divide(lo - s, d);
            b = q_divide(hi - s, d);
            if (a > b) begin t = a; a = b; b = t; end
         end
         if (ax == 0) begin
            tmin = a;
            tmax = b;
         end else begin
            if (tmin > b || a > tmax) return r;
            if (a > tmin) tmin = a;
            if (b < tmax) tmax = b;
         end
      end
      r.hit = 1'b1;
      r.entry = tmin[31:0];
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 40 << 16))) - (20 << 16);
      endcase
   endfunction

   function automatic logic [383:0] rand_ray();
      logic [383:0] v;
      for (int i = 0; i < 12; i++) v[32*i +: 32] = rand_coord();
      // axis-parallel segments and degenerate points now and then
      for (int ax = 0; ax < 3; ax++)
         if ($urandom_range(0, 5) == 0) v[32*(3+ax) +: 32] = v[32*ax +: 32];
      return v;
   endfunction

   // driver: the offered item stays at the queue front until its transfer
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         isect_expected.push_back(predict_isect(req_tdata));
         void'(ray_queue.pop_front());
      end
      if (!req_tvalid || req_tready) begin
         if (ray_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= ray_queue[0];
         end else
            req_tvalid <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (isect_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer hit=%0b entry=%h",
                                          rsp_tuser, rsp_tdata);
         end else begin
            isect_type x;
            x = isect_expected.pop_front();
            if (x.hit !== rsp_tuser[0] || x.entry !== rsp_tdata) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hit=%0b entry=%h, got hit=%0b entry=%h",
                           x.hit, x.entry, rsp_tuser, rsp_tdata);
            end
         end
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= !reset && ($urandom_range(0, 99) >= snk_stall_pct);
   end

   task automatic run_phase(int n, int idle, int stall);
      src_idle_pct = idle;
      snk_stall_pct = stall;
      for (int i = 0; i < n; i++) ray_queue.push_back(rand_ray());
      while (ray_queue.size() > 0) @(posedge clock);
   endtask

   initial begin
      logic [383:0] v;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      v = '0;
      for (int ax = 0; ax < 3; ax++) begin
         v[32*(3+ax) +: 32] = 32'h0001_0000;
         v[32*(6+ax) +: 32] = 32'hFFFF_0000;
         v[32*(9+ax) +: 32] = 32'h0001_0000;
      end
      ray_queue.push_back(v);                       // diagonal through unit box
      v[32*3 +: 32] = 32'h0;
      ray_queue.push_back(v);                       // x parallel, inside slab
      v[32*0 +: 32] = 32'h0005_0000; v[32*3 +: 32] = 32'h0005_0000;
      ray_queue.push_back(v);                       // x parallel, outside
      v = '0;
      for (int ax = 0; ax < 3; ax++) begin
         v[32*(6+ax) +: 32] = 32'h0001_0000;        // swapped bounds
         v[32*(9+ax) +: 32] = 32'hFFFF_0000;
      end
      ray_queue.push_back(v);                       // degenerate point inside
      for (int i = 0; i < 12; i++) v[32*i +: 32] = 32'h8000_0000;
      ray_queue.push_back(v);
      for (int i = 0; i < 12; i++) v[32*i +: 32] = 32'h7FFF_FFFF;
      ray_queue.push_back(v);
      v = '0;
      v[32*3 +: 32] = 32'h0000_0001;                // tiny direction, saturation
      v[32*6 +: 32] = 32'h7FFF_FFFF; v[32*9 +: 32] = 32'h8000_0000;
      for (int ax = 1; ax < 3; ax++) v[32*(9+ax) +: 32] = 32'h0001_0000;
      ray_queue.push_back(v);
      v = '0;                                       // touching intervals
      v[32*3 +: 32] = 32'h0001_0000; v[32*4 +: 32] = 32'h0001_0000;
      v[32*6 +: 32] = 32'h0000_8000; v[32*9 +: 32] = 32'h0001_0000;
      v[32*7 +: 32] = 32'h0000_0000; v[32*10 +: 32] = 32'h0000_8000;
      v[32*11 +: 32] = 32'h0001_0000;
      ray_queue.push_back(v);
      for (int i = 0; i < 12; i++) v[32*i +: 32] = 32'h8000_0000 ^ {32{i[0]}};
      ray_queue.push_back(v);
      while (ray_queue.size() > 0) @(posedge clock);
      run_phase(250, 0, 0);
      run_phase(250, 57, 0);
      run_phase(250, 0, 57);
      // long sink hold-off while the source keeps offering
      hold_off <= 200;
      run_phase(100, 0, 0);
      // source pause until drained
      while (isect_expected.size() > 0) @(posedge clock);
      run_phase(250, 33, 33);
      while (isect_expected.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rbsi_pkg.sv
hw/rtl/rbsi_div.sv
hw/rtl/ray_box_slab_intersect.sv
tb/tb_top.sv
